// ===== hw/rtl/asocf_pkg.sv =====
// Shared types, constants and functions of the accelerometer sample orientation and change filter.
package asocf_pkg;

  localparam int unsigned SCALE_STEP = 61;
  localparam logic signed [8:0] SCALE_STEP_S = 9'(SCALE_STEP);

  localparam int unsigned RAW_W    = 16;
  localparam int unsigned SCALED_W = 22;
  localparam int unsigned AXIS_W   = 24;
  localparam int unsigned ROW_W    = 6;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W = 56;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [3:0] STATUS_READY_MASK = 4'hf;

  localparam logic [CFG_IDX_W-1:0] REG_ORIENT_ROW_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENT_ROW_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENT_ROW_Z     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 2'd3;

  localparam logic [ROW_W-1:0] ROW_X_RESET     = 6'd1;
  localparam logic [ROW_W-1:0] ROW_Y_RESET     = 6'd4;
  localparam logic [ROW_W-1:0] ROW_Z_RESET     = 6'd16;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd10;

  localparam logic [1:0] WEIGHT_PLUS  = 2'd1;
  localparam logic [1:0] WEIGHT_MINUS = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0] row_x;
    logic [ROW_W-1:0] row_y;
    logic [ROW_W-1:0] row_z;
    logic [THR_W-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic                       not_ready;
    logic signed [SCALED_W-1:0] x;
    logic signed [SCALED_W-1:0] y;
    logic signed [SCALED_W-1:0] z;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } q_head_t;

  function automatic logic signed [AXIS_W-1:0] weigh(logic [1:0] code,
                                                     logic signed [SCALED_W-1:0] v);
    logic signed [AXIS_W-1:0] ext;
    logic signed [AXIS_W-1:0] res;
    ext = AXIS_W'(v);
    case (code)
      WEIGHT_PLUS:  res = ext;
      WEIGHT_MINUS: res = -ext;
      default:      res = '0;
    endcase
    return res;
  endfunction

  function automatic logic signed [AXIS_W-1:0] remap_row(logic [ROW_W-1:0] row,
                                                         logic signed [SCALED_W-1:0] x,
                                                         logic signed [SCALED_W-1:0] y,
                                                         logic signed [SCALED_W-1:0] z);
    return weigh(row[1:0], x) + weigh(row[3:2], y) + weigh(row[5:4], z);
  endfunction

  function automatic logic exceeds(logic signed [AXIS_W-1:0] now_v,
                                   logic signed [AXIS_W-1:0] prev_v,
                                   logic [THR_W-1:0] thr);
    logic signed [AXIS_W:0] d;
    logic [AXIS_W:0]        mag;
    d   = (AXIS_W+1)'(now_v) - (AXIS_W+1)'(prev_v);
    mag = d[AXIS_W] ? (AXIS_W+1)'(-d) : (AXIS_W+1)'(d);
    return mag > (AXIS_W+1)'(thr);
  endfunction

endpackage

// ===== hw/rtl/asocf_front.sv =====
// Front part: classifies each sample word and scales its three axes.
module asocf_front (
  input  logic [asocf_pkg::IN_DATA_W-1:0] in_data,
  output asocf_pkg::qent_t                ent
);
  import asocf_pkg::*;

  logic signed [RAW_W-1:0] raw_x, raw_y, raw_z;
  logic signed [RAW_W+8:0] prod_x, prod_y, prod_z;

  assign raw_x = in_data[23:8];
  assign raw_y = in_data[39:24];
  assign raw_z = in_data[55:40];

  assign prod_x = raw_x * SCALE_STEP_S;
  assign prod_y = raw_y * SCALE_STEP_S;
  assign prod_z = raw_z * SCALE_STEP_S;

  assign ent.not_ready = (in_data[3:0] & STATUS_READY_MASK) == 4'd0;
  assign ent.x = prod_x[SCALED_W-1:0];
  assign ent.y = prod_y[SCALED_W-1:0];
  assign ent.z = prod_z[SCALED_W-1:0];

endmodule

// ===== hw/rtl/asocf_queue.sv =====
// Two-entry queue between the front and back parts.
module asocf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  asocf_pkg::qent_t  push_ent,
  output logic              full,
  input  logic              pop,
  output asocf_pkg::q_head_t head
);
  import asocf_pkg::*;

  qent_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = count_r == 2'd2;
  assign head.valid = count_r != 2'd0;
  assign head.ent   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

// ===== hw/rtl/asocf_back.sv =====
// Back part: remaps the scaled vector, applies the change threshold and holds the result word.
module asocf_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  asocf_pkg::cfg_t                   cfg,
  input  asocf_pkg::q_head_t                head,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [asocf_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [asocf_pkg::OUT_USER_W-1:0]  out_tuser
);
  import asocf_pkg::*;

  logic signed [AXIS_W-1:0] ax, ay, az;
  logic signed [AXIS_W-1:0] last_x_r, last_y_r, last_z_r;
  logic                     changed, report;
  logic                     valid_r, valid_nxt;
  logic [OUT_DATA_W-1:0]    data_r;
  logic [OUT_USER_W-1:0]    user_r;

  assign ax = remap_row(cfg.row_x, head.ent.x, head.ent.y, head.ent.z);
  assign ay = remap_row(cfg.row_y, head.ent.x, head.ent.y, head.ent.z);
  assign az = remap_row(cfg.row_z, head.ent.x, head.ent.y, head.ent.z);

  assign changed = exceeds(ax, last_x_r, cfg.threshold) ||
                   exceeds(ay, last_y_r, cfg.threshold) ||
                   exceeds(az, last_z_r, cfg.threshold);

  assign pop    = head.valid && (!valid_r || out_tready);
  assign report = pop && !head.ent.not_ready && changed;

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      last_x_r <= '0;
      last_y_r <= '0;
      last_z_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (report) begin
        last_x_r <= ax;
        last_y_r <= ay;
        last_z_r <= az;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      user_r <= {report, head.ent.not_ready};
      data_r <= report ? {az, ay, ax} : '0;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

// ===== hw/rtl/accel_sample_orient_change_filter.sv =====
// Top level of the accelerometer sample orientation and change filter.
//
//   port group | direction | tdata fields, lowest bit up                 | tuser
//   in_        | slave     | status, x_low, x_high, y_low, y_high, z_low, | -
//              |           | z_high                                      |
//   out_       | master    | axis_out_x, axis_out_y, axis_out_z          | not_ready,
//              |           |                                             | report_valid
//   cfg_       | write     | index 0..3: row x, row y, row z, threshold  | -
//
// A word passes through the queue to the result register: the scaling multipliers feed the queue
// at the accepting edge, and the remap and threshold compare fill the result register when the
// word is popped from the queue head.
// One word is accepted per cycle while the output flows; the two-entry queue absorbs stalls.
// Reset sets the configuration registers to their defaults, the last reported vector to zero and clears the queue.
module accel_sample_orient_change_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // status_byte, x_low, x_high, y_low, y_high, z_low, z_high
  input  logic [asocf_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // axis_out_x, axis_out_y, axis_out_z
  output logic [asocf_pkg::OUT_DATA_W-1:0]    out_tdata,
  // not_ready, report_valid
  output logic [asocf_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic                                cfg_we,
  input  logic [asocf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [asocf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import asocf_pkg::*;

  cfg_t    cfg_r;
  qent_t   front_ent;
  q_head_t head;
  logic    q_full, push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_x     <= ROW_X_RESET;
      cfg_r.row_y     <= ROW_Y_RESET;
      cfg_r.row_z     <= ROW_Z_RESET;
      cfg_r.threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIENT_ROW_X:     cfg_r.row_x     <= cfg_wdata[ROW_W-1:0];
        REG_ORIENT_ROW_Y:     cfg_r.row_y     <= cfg_wdata[ROW_W-1:0];
        REG_ORIENT_ROW_Z:     cfg_r.row_z     <= cfg_wdata[ROW_W-1:0];
        REG_CHANGE_THRESHOLD: cfg_r.threshold <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  asocf_front u_front (
    .in_data (in_tdata),
    .ent     (front_ent)
  );

  asocf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (front_ent),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  asocf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("not_ready and report_valid both set");

  a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[1]) |-> (out_tdata == '0))
    else $error("unreported word carries nonzero axes");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("queue full while the output register is empty");

  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("queue popped while empty");

endmodule
